// ===== rtl/core/rsad_pkg.sv =====
// Shared constants and types of the running packet-size anomaly detector.
package rsad_pkg;

    localparam int COUNT_BITS     = 20;
    localparam int MEAN_FRAC_BITS = 16;

    localparam int SIZE_W   = 16;
    localparam int SIGMA_W  = 4;
    localparam int S2_W     = 2 * SIGMA_W;
    localparam int MEAN_W   = SIZE_W + MEAN_FRAC_BITS;
    localparam int SUM_W    = 64;
    localparam int SUM_FRAC = 8;
    // aligns the Q56.8 sum with the 2F fraction bits of a squared deviation
    localparam int SUM_SHIFT = 2 * MEAN_FRAC_BITS - SUM_FRAC;

    // shared multiplier operand width
    localparam int MUL_W      = (MEAN_W > COUNT_BITS) ? MEAN_W : COUNT_BITS;
    localparam int SUM_CHUNKS = (SUM_W + MUL_W - 1) / MUL_W;
    localparam int SUM_PAD_W  = SUM_CHUNKS * MUL_W;
    localparam int KW         = $clog2(SUM_CHUNKS);
    localparam int ACC_CHUNKS = (SUM_CHUNKS + 1 > 3) ? SUM_CHUNKS + 1 : 3;
    localparam int ACC_W      = ACC_CHUNKS * MUL_W;
    localparam int CMP_W      = ACC_W + SUM_SHIFT;
    localparam int INC_W      = 2 * MEAN_W - SUM_SHIFT;
    localparam int DIV_CW     = $clog2(MEAN_W + 1);

    localparam logic [MEAN_W-1:0]     MEAN_RESET  = MEAN_W'(500) << MEAN_FRAC_BITS;
    localparam logic [SUM_W-1:0]      SUM_RESET   = SUM_W'(10000) << SUM_FRAC;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [SIGMA_W-1:0]    SIGMA_RESET = SIGMA_W'(3);
    localparam logic [KW-1:0]         K_TOP       = KW'(SUM_CHUNKS - 1);

    typedef struct packed {
        logic             issue;
        logic             clr;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_op;

endpackage

// ===== rtl/core/rsad_if.sv =====
// Channel interfaces: packet sizes in, results out, sigma factor writes.
interface rsad_pkt_if;
    logic                        valid;
    logic                        ready;
    logic [rsad_pkg::SIZE_W-1:0] packet_size;

    modport source (output valid, output packet_size, input ready);
    modport sink (input valid, input packet_size, output ready);
endinterface

interface rsad_res_if;
    logic                        valid;
    logic                        ready;
    logic                        anomaly;
    logic [rsad_pkg::SIZE_W-1:0] mean_estimate;

    modport source (output valid, output anomaly, output mean_estimate, input ready);
    modport sink (input valid, input anomaly, input mean_estimate, output ready);
endinterface

interface rsad_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rsad_pkg::SIGMA_W-1:0] sigma_factor;

    modport source (output valid, output sigma_factor, input ready);
    modport sink (input valid, input sigma_factor, output ready);
endinterface

// ===== rtl/core/rsad_mul.sv =====
// Shared multiplier with a registered product and a shift-accumulate stage.
module rsad_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rsad_pkg::t_mul_op              i_op,
    output logic [rsad_pkg::ACC_W-1:0]     o_acc
);
    import rsad_pkg::*;

    logic [2*MUL_W-1:0] prod;
    logic [2*MUL_W-1:0] r_prod;
    logic               r_vld;
    logic               r_clr;
    logic [ACC_W-1:0]   r_acc;

    assign prod  = i_op.a * i_op.b;
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_op.issue;
        end
        r_prod <= prod;
        r_clr  <= i_op.clr;
    end

    // partial products arrive most significant chunk first
    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            if (r_clr) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= (r_acc << MUL_W) + ACC_W'(r_prod);
            end
        end
    end

endmodule

// ===== rtl/core/rsad_div.sv =====
// Radix-2 restoring divider: mean deviation over sample count.
module rsad_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rsad_pkg::MEAN_W-1:0]       i_dividend,
    input  logic [rsad_pkg::COUNT_BITS-1:0]   i_divisor,
    output logic [rsad_pkg::MEAN_W-1:0]       o_quot,
    output logic                              o_busy
);
    import rsad_pkg::*;

    logic [MEAN_W-1:0]     r_q;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_dvs;
    logic [DIV_CW-1:0]     r_cnt;
    logic [COUNT_BITS:0]   rem_sh;
    logic [COUNT_BITS+1:0] diff;
    logic                  borrow;

    assign rem_sh = {r_rem, r_q[MEAN_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign borrow = diff[COUNT_BITS+1];
    assign o_quot = r_q;
    assign o_busy = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CW'(MEAN_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // dividend shifts out the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            r_q   <= {r_q[MEAN_W-2:0], ~borrow};
            r_rem <= borrow ? rem_sh[COUNT_BITS-1:0] : diff[COUNT_BITS-1:0];
        end
    end

endmodule

// ===== rtl/core/running_size_anomaly_detector.sv =====
// Top level: sequencer, statistics registers and result register.
//
// Channels: i_pkt carries one packet size per beat, o_res returns one beat
// per packet (anomaly flag and the integer part of the mean before that
// packet), i_cfg writes the sigma factor and is always ready. Write it only
// while no packet is in flight.
// A packet is taken only when the sequencer is idle. The result beat is
// offered from the result register once the compare step has run. After an
// anomalous packet the sequencer returns to idle from the compare step; after
// a clean one it waits for the radix-2 divider, which forms the mean step one
// quotient bit per cycle, and then updates the statistics.
// Squared deviation times count and sigma^2 times sum are built from
// partial products on one shared multiplier and compared exactly.
// Reset sets the mean to 500, the sum to 10000, the count to 1 and the
// sigma factor to 3, and empties the result register.
// A stalled receiver holds the result register; the sequencer waits at the
// compare step until the register frees, and a new packet size may be
// accepted while the last result is still waiting.
module running_size_anomaly_detector (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsad_cfg_if.sink     i_cfg,
    rsad_pkt_if.sink     i_pkt,
    rsad_res_if.source   o_res
);
    import rsad_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_SQW  = 4'd2;
    localparam logic [3:0] ST_LHI  = 4'd3;
    localparam logic [3:0] ST_LLO  = 4'd4;
    localparam logic [3:0] ST_LW   = 4'd5;
    localparam logic [3:0] ST_RHS  = 4'd6;
    localparam logic [3:0] ST_RW   = 4'd7;
    localparam logic [3:0] ST_CMP  = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_INC  = 4'd10;
    localparam logic [3:0] ST_INCW = 4'd11;
    localparam logic [3:0] ST_UPD  = 4'd12;

    logic [3:0]            r_state;
    logic [MEAN_W-1:0]     r_mean;
    logic [SUM_W-1:0]      r_sum;
    logic [COUNT_BITS-1:0] r_count;
    logic [SIGMA_W-1:0]    r_sigma;
    logic                  r_neg;
    logic [MEAN_W-1:0]     r_mag;
    logic [MUL_W-1:0]      r_sq_lo;
    logic [ACC_W-1:0]      r_lhs;
    logic [KW-1:0]         r_k;
    logic [MEAN_W-1:0]     r_nm;
    logic [MEAN_W-1:0]     r_d2;
    logic                  r_out_vld;
    logic                  r_anom;
    logic [SIZE_W-1:0]     r_mest;

    logic [MEAN_W-1:0]     x;
    logic                  x_below;
    logic [S2_W-1:0]       s2;
    logic [SUM_PAD_W-1:0]  sum_pad;
    t_mul_op               mul_op;
    logic [ACC_W-1:0]      mul_acc;
    logic                  div_busy;
    logic [MEAN_W-1:0]     div_q;
    logic                  anom;
    logic [INC_W-1:0]      inc;
    logic [SUM_W:0]        sum_t;

    assign x       = {i_pkt.packet_size, {MEAN_FRAC_BITS{1'b0}}};
    assign x_below = (x < r_mean);
    assign s2      = r_sigma * r_sigma;
    assign sum_pad = SUM_PAD_W'(r_sum);
    // exact test: dev^2 * count > sigma^2 * sum, both at 2F fraction bits
    assign anom    = CMP_W'(r_lhs) > (CMP_W'(mul_acc) << SUM_SHIFT);
    assign inc     = mul_acc[2*MEAN_W-1:SUM_SHIFT];
    assign sum_t   = {1'b0, r_sum} + (SUM_W + 1)'(inc);

    assign i_cfg.ready         = 1'b1;
    assign i_pkt.ready         = (r_state == ST_IDLE);
    assign o_res.valid         = r_out_vld;
    assign o_res.anomaly       = r_anom;
    assign o_res.mean_estimate = r_mest;

    always_comb begin
        mul_op = '0;
        unique case (r_state)
            ST_SQ: begin
                mul_op.issue = 1'b1;
                mul_op.clr   = 1'b1;
                mul_op.a     = MUL_W'(r_mag);
                mul_op.b     = MUL_W'(r_mag);
            end
            ST_LHI: begin
                mul_op.issue = 1'b1;
                mul_op.clr   = 1'b1;
                mul_op.a     = MUL_W'(mul_acc[2*MEAN_W-1:MUL_W]);
                mul_op.b     = MUL_W'(r_count);
            end
            ST_LLO: begin
                mul_op.issue = 1'b1;
                mul_op.a     = r_sq_lo;
                mul_op.b     = MUL_W'(r_count);
            end
            ST_RHS: begin
                mul_op.issue = 1'b1;
                mul_op.clr   = (r_k == K_TOP);
                mul_op.a     = sum_pad[r_k*MUL_W +: MUL_W];
                mul_op.b     = MUL_W'(s2);
            end
            ST_INC: begin
                mul_op.issue = 1'b1;
                mul_op.clr   = 1'b1;
                mul_op.a     = MUL_W'(r_mag);
                mul_op.b     = MUL_W'(r_d2);
            end
            default: begin
            end
        endcase
    end

    rsad_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mul_op),
        .o_acc   (mul_acc)
    );

    rsad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_SQ),
        .i_dividend (r_mag),
        .i_divisor  (r_count),
        .o_quot     (div_q),
        .o_busy     (div_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mean    <= MEAN_RESET;
            r_sum     <= SUM_RESET;
            r_count   <= COUNT_RESET;
            r_sigma   <= SIGMA_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_sigma <= i_cfg.sigma_factor;
            end
            // the compare step refills the register itself
            if (r_out_vld && o_res.ready && r_state != ST_CMP) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pkt.valid) begin
                        r_neg   <= x_below;
                        r_mag   <= x_below ? (r_mean - x) : (x - r_mean);
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_state <= ST_SQW;
                end
                ST_SQW: begin
                    r_state <= ST_LHI;
                end
                ST_LHI: begin
                    r_sq_lo <= mul_acc[MUL_W-1:0];
                    r_state <= ST_LLO;
                end
                ST_LLO: begin
                    r_state <= ST_LW;
                end
                ST_LW: begin
                    r_k     <= K_TOP;
                    r_state <= ST_RHS;
                end
                ST_RHS: begin
                    // first cycle here sees the finished left side
                    if (r_k == K_TOP) begin
                        r_lhs <= mul_acc;
                    end
                    if (r_k == '0) begin
                        r_state <= ST_RW;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                ST_RW: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (!r_out_vld || o_res.ready) begin
                        r_out_vld <= 1'b1;
                        r_anom    <= anom;
                        r_mest    <= r_mean[MEAN_W-1:MEAN_FRAC_BITS];
                        r_state   <= anom ? ST_IDLE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!div_busy) begin
                        r_nm    <= r_neg ? (r_mean - div_q) : (r_mean + div_q);
                        // distance from size to new mean is mag minus the step
                        r_d2    <= r_mag - div_q;
                        r_state <= ST_INC;
                    end
                end
                ST_INC: begin
                    r_state <= ST_INCW;
                end
                ST_INCW: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_mean <= r_nm;
                    r_sum  <= sum_t[SUM_W] ? {SUM_W{1'b1}} : sum_t[SUM_W-1:0];
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/tb_running_size_anomaly_detector.sv =====
// Self-checking testbench of the running packet-size anomaly detector.
`timescale 1ns / 1ps

module tb_running_size_anomaly_detector;
    import rsad_pkg::*;

    localparam int WIDE_W      = 128;
    localparam int PROD_W      = 2 * MEAN_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 60;
    localparam int LONG_HOLD   = 400;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 235;

    localparam logic [MEAN_W-1:0]     MEAN_AT_RESET  = MEAN_W'(500) << MEAN_FRAC_BITS;
    localparam logic [SUM_W-1:0]      SUMSQ_AT_RESET = SUM_W'(10000) << SUM_FRAC;
    localparam logic [COUNT_BITS-1:0] COUNT_AT_RESET = COUNT_BITS'(1);
    localparam logic [SIGMA_W-1:0]    SIGMA_AT_RESET = SIGMA_W'(3);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP      = '1;
    localparam logic [SIZE_W-1:0]     SIZE_TOP       = '1;

    typedef struct packed {
        logic              anomaly;
        logic [SIZE_W-1:0] mean_estimate;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rsad_cfg_if cfg_ch ();
    rsad_pkt_if pkt_ch ();
    rsad_res_if res_ch ();

    running_size_anomaly_detector uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pkt   (pkt_ch),
        .o_res   (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [MEAN_W-1:0]     mean_q;
    logic [SUM_W-1:0]      sumsq_q;
    logic [COUNT_BITS-1:0] count_q;
    logic [SIGMA_W-1:0]    sigma_q;

    logic [SIZE_W-1:0] size_backlog[$];
    t_verdict          pending_verdicts[$];
    t_verdict          want;

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  flagged_seen   = 0;
    int  sigma_writes   = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    bit  hold_req       = 1'b0;
    bit  hold_seen      = 1'b0;
    bit  idle_on        = 1'b1;

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Expected verdict for one size; a clean size folds into the statistics.
    function automatic t_verdict judge_size(input logic [SIZE_W-1:0] size);
        logic [MEAN_W-1:0]  x;
        logic [MEAN_W-1:0]  mag;
        logic [MEAN_W-1:0]  step;
        logic [MEAN_W-1:0]  nm;
        logic [MEAN_W-1:0]  d2;
        logic [WIDE_W-1:0]  lhs;
        logic [WIDE_W-1:0]  rhs;
        logic [PROD_W-1:0]  prod;
        logic [SUM_W:0]     total;
        t_verdict           v;
        x   = MEAN_W'(size) << MEAN_FRAC_BITS;
        mag = (x >= mean_q) ? x - mean_q : mean_q - x;
        // exact test: dev^2 * count against sigma^2 * sum, sum moved to 2F fraction bits
        lhs = WIDE_W'(mag) * WIDE_W'(mag) * WIDE_W'(count_q);
        rhs = (WIDE_W'(sumsq_q) * WIDE_W'(sigma_q) * WIDE_W'(sigma_q)) << SUM_SHIFT;
        v.anomaly       = (lhs > rhs);
        v.mean_estimate = mean_q[MEAN_W-1:MEAN_FRAC_BITS];
        if (!v.anomaly) begin
            step = mag / MEAN_W'(count_q);
            if (x >= mean_q) begin
                nm = mean_q + step;
                d2 = x - nm;
            end else begin
                nm = mean_q - step;
                d2 = nm - x;
            end
            mean_q  = nm;
            prod    = PROD_W'(mag) * PROD_W'(d2);
            total   = (SUM_W+1)'(sumsq_q) + (SUM_W+1)'(prod >> SUM_SHIFT);
            sumsq_q = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
            if (count_q != COUNT_TOP)
                count_q = count_q + 1'b1;
        end
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input int value);
        if (value < 0)
            return '0;
        if (value > int'(SIZE_TOP))
            return SIZE_TOP;
        return SIZE_W'(value);
    endfunction

    // driver: offers backlog sizes, predicts each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_ch.valid       <= 1'b0;
            pkt_ch.packet_size <= '0;
            gap_left           <= 0;
        end else begin
            if (pkt_ch.valid && pkt_ch.ready)
                pending_verdicts.push_back(judge_size(pkt_ch.packet_size));
            if (!pkt_ch.valid || pkt_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left     <= gap_left - 1;
                    pkt_ch.valid <= 1'b0;
                end else if (size_backlog.size() > 0) begin
                    pkt_ch.valid       <= 1'b1;
                    pkt_ch.packet_size <= size_backlog.pop_front();
                    if (idle_on && $urandom_range(0, 4) == 0)
                        gap_left <= $urandom_range(1, 10);
                end else begin
                    pkt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result beats and drives ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (res_ch.anomaly)
                    flagged_seen++;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = pending_verdicts.pop_front();
                    if (res_ch.anomaly !== want.anomaly)
                        report_mismatch($sformatf("anomaly %b, expected %b",
                                                  res_ch.anomaly, want.anomaly));
                    if (res_ch.mean_estimate !== want.mean_estimate)
                        report_mismatch($sformatf("mean_estimate %0d, expected %0d",
                                                  res_ch.mean_estimate, want.mean_estimate));
                end
            end
            if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left   <= $urandom_range(0, 9);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off, started by a toggle of hold_req
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_left <= LONG_HOLD;
            hold_seen <= hold_req;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_verdicts.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_sigma(input logic [SIGMA_W-1:0] value);
        @(posedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.sigma_factor <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        sigma_q = value;
        sigma_writes++;
    endtask

    // wait for every result, then let the divider finish its last clean packet
    task automatic drain;
        do
            @(negedge i_clk);
        while (size_backlog.size() != 0 || pkt_ch.valid || pending_verdicts.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // sizes clustered around the current mean, with uniform noise and extremes
    task automatic queue_cluster(input int count, input int spread);
        int center;
        int offset;
        int pick;
        int k;
        center = int'(mean_q[MEAN_W-1:MEAN_FRAC_BITS]);
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                size_backlog.push_back(pick[0] ? SIZE_TOP : '0);
            end else if (pick < 13) begin
                size_backlog.push_back(SIZE_W'($urandom_range(0, 65535)));
            end else begin
                offset = (int'($urandom_range(0, 2 * spread))
                          + int'($urandom_range(0, 2 * spread))) / 2 - spread;
                size_backlog.push_back(clamp_size(center + offset));
            end
            if ($urandom_range(0, 7) == 0)
                center = int'(clamp_size(center + int'($urandom_range(0, spread / 2))
                                         - spread / 4));
        end
    endtask

    logic [SIGMA_W-1:0] phase_sigma[PHASES] = '{3, 15, 1, 6, 2, 10, 4, 3};
    int                 phase_spread[PHASES] = '{64, 2000, 8, 300, 20000, 1000, 150, 40};

    initial begin
        int ph;
        cfg_ch.valid        = 1'b0;
        cfg_ch.sigma_factor = '0;
        pkt_ch.valid        = 1'b0;
        pkt_ch.packet_size  = '0;
        res_ch.ready        = 1'b0;
        mean_q  = MEAN_AT_RESET;
        sumsq_q = SUMSQ_AT_RESET;
        count_q = COUNT_AT_RESET;
        sigma_q = SIGMA_AT_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset sigma: exact mean, sizes 300 above and below it, extremes
        size_backlog.push_back(16'd500);
        size_backlog.push_back(16'd800);
        size_backlog.push_back(16'd200);
        size_backlog.push_back(16'd0);
        size_backlog.push_back(SIZE_TOP);
        drain();

        // sigma zero: only a size equal to the mean passes
        write_sigma(4'd0);
        size_backlog.push_back(16'd800);
        size_backlog.push_back(16'd801);
        size_backlog.push_back(16'd799);
        size_backlog.push_back(16'hAAAA);
        size_backlog.push_back(16'h5555);
        size_backlog.push_back(16'd800);
        drain();

        write_sigma(4'd15);
        size_backlog.push_back(16'd0);
        size_backlog.push_back(SIZE_TOP);
        size_backlog.push_back(16'd1);
        size_backlog.push_back(16'h8000);
        size_backlog.push_back(16'd2000);
        size_backlog.push_back(16'd4000);
        drain();

        write_sigma(4'd1);
        size_backlog.push_back(16'd700);
        size_backlog.push_back(16'd900);
        size_backlog.push_back(16'd850);
        size_backlog.push_back(16'd860);
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            write_sigma(phase_sigma[ph]);
            idle_on = (ph != 3 && ph != PHASES - 1);
            queue_cluster(PHASE_ITEMS, phase_spread[ph]);
            // receiver holds off while the sender keeps offering sizes
            if (ph == 1)
                hold_req = ~hold_req;
            drain();
        end

        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never returned", pending_verdicts.size()));
        $display("summary: %0d packet sizes checked under %0d sigma writes, %0d flagged",
                 results_seen, sigma_writes, flagged_seen);
        $display("summary: mean ended at %0d, sample count %0d",
                 mean_q[MEAN_W-1:MEAN_FRAC_BITS], count_q);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rsad_pkg.sv
rtl/core/rsad_if.sv
rtl/core/rsad_mul.sv
rtl/core/rsad_div.sv
rtl/core/running_size_anomaly_detector.sv
verif/tb_running_size_anomaly_detector.sv
